/* sv/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms clocked on aclk with the reset applied.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

/* sv/i2p_pkg.sv */
// ============================================================================
// Infix to postfix converter package
// Character codes, stack codes, command and status types shared by the unit.
// ============================================================================
`timescale 1ns / 1ps

package i2p_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    typedef logic [2:0] code_t;

    localparam code_t CODE_NONE = 3'd0;
    localparam code_t CODE_OPEN = 3'd1;
    localparam code_t CODE_ADD  = 3'd2;
    localparam code_t CODE_SUB  = 3'd3;
    localparam code_t CODE_MUL  = 3'd4;
    localparam code_t CODE_DIV  = 3'd5;

    typedef enum logic [2:0] {
        CLS_OPERAND,
        CLS_SPACE,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP
    } char_class_t;

    typedef struct packed {
        logic load;
        logic produce;
        logic prod_top;
        logic pop;
        logic push;
        logic push_open;
        logic set_unmatched;
        logic finish;
    } cmd_t;

    typedef struct packed {
        char_class_t cls;
        logic        eoe;
        logic        empty;
        logic        full;
        logic        top_open;
        logic        top_lower;
        logic        pend_valid;
        logic        out_free;
    } status_t;

    function automatic code_t code_of(input logic [7:0] c);
        case (c)
            CH_ADD:  return CODE_ADD;
            CH_SUB:  return CODE_SUB;
            CH_MUL:  return CODE_MUL;
            CH_DIV:  return CODE_DIV;
            default: return CODE_NONE;
        endcase
    endfunction

    function automatic logic [7:0] code_char(input code_t code);
        case (code)
            CODE_OPEN: return CH_OPEN;
            CODE_ADD:  return CH_ADD;
            CODE_SUB:  return CH_SUB;
            CODE_MUL:  return CH_MUL;
            CODE_DIV:  return CH_DIV;
            default:   return CH_NUL;
        endcase
    endfunction

    function automatic logic [1:0] prec_of(input code_t code);
        case (code) inside
            CODE_ADD, CODE_SUB: return 2'd1;
            CODE_MUL, CODE_DIV: return 2'd2;
            default:            return 2'd0;
        endcase
    endfunction

endpackage

/* sv/infix_to_postfix_converter_unit.sv */
// Sequence: a space, operand or '(' passes S_DECODE, S_NEXT and S_FINISH from transfer to the next ready;
// its result is presented in the cycle that ready returns; output stalls can hold S_DECODE or S_FINISH.
// Each operator popped by ')' or an operator adds a pass through S_POP_WAIT (stack read latency).
// End of expression adds S_FLUSH_CHK plus an S_FLUSH_WAIT pass per flushed stack entry; one item at a time.
// Reset: aresetn is synchronous and active low; it empties the stack and clears errors.
// The stack memory itself is not cleared; only entries below the count are read.
// ============================================================================
// Infix to postfix converter
// Shunting-yard conversion of a character stream with sticky error report.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [7:0] out_char, [9:8] expr_error, zero pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser   // [0] char_valid, [1] expr_done
);
    import i2p_pkg::*;

    cmd_t    cmd;
    status_t status;

    i2p_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2p_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `ASSERT_CLK(a_done_is_last, (m_tvalid && m_tuser[1]) |-> m_tlast, "expr_done without last")
    `ASSERT_CLK(a_err_with_done, (m_tvalid && (m_tdata[9:8] != 2'b00)) |-> m_tuser[1], "error without done")
    `ASSERT_CLK(a_marker_is_done, (m_tvalid && !m_tuser[0]) |-> m_tuser[1], "bare marker without done")
    `ASSERT_CLK(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "second transfer while busy")
    `ASSERT_NEVER(a_push_pop, cmd.push && cmd.pop, "push and pop in one cycle")

endmodule

/* sv/i2p_dpath.sv */
// ============================================================================
// Infix to postfix datapath
// Input register, operator stack memory, pending result and output register.
// ============================================================================
`timescale 1ns / 1ps

module i2p_dpath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  i2p_pkg::cmd_t    cmd,
    output i2p_pkg::status_t status,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [15:0]      m_tdata,  // [7:0] out_char, [9:8] expr_error, zero pad
    output logic             m_tlast,
    output logic [1:0]       m_tuser   // [0] char_valid, [1] expr_done
);
    import i2p_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    logic [7:0]    ch_reg;
    logic          eoe_reg;
    code_t         op_code;
    char_class_t   cls;

    logic [CW-1:0] count_reg, count_next, count_dec;
    logic [1:0]    err_reg, err_next;
    code_t         stack_mem [STACK_DEPTH];
    code_t         top_reg;
    code_t         push_code;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          full;

    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_char_reg, pend_char_next;
    logic [7:0]    prod_char;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_char_reg, m_char_next;
    logic          m_cv_reg, m_cv_next;
    logic          m_last_reg, m_last_next;
    logic          m_done_reg, m_done_next;
    logic [1:0]    m_err_reg, m_err_next;

    assign op_code   = code_of(ch_reg);
    assign count_dec = count_reg - CW'(1);
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_addr   = count_dec[AW-1:0];
    assign full      = (count_reg == DEPTH_C);
    assign push_code = cmd.push_open ? CODE_OPEN : op_code;
    assign prod_char = cmd.prod_top ? code_char(top_reg) : ch_reg;

    always_comb begin
        case (ch_reg)
            CH_SPACE: cls = CLS_SPACE;
            CH_OPEN:  cls = CLS_OPEN;
            CH_CLOSE: cls = CLS_CLOSE;
            default:  cls = (op_code != CODE_NONE) ? CLS_OP : CLS_OPERAND;
        endcase
    end

    always_comb begin
        status.cls        = cls;
        status.eoe        = eoe_reg;
        status.empty      = (count_reg == '0);
        status.full       = full;
        status.top_open   = (top_reg == CODE_OPEN);
        status.top_lower  = (prec_of(top_reg) < prec_of(op_code));
        status.pend_valid = pend_valid_reg;
        status.out_free   = !m_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && !full) begin
            stack_mem[wr_addr] <= push_code;
        end
        top_reg <= stack_mem[rd_addr];
    end

    always_comb begin
        count_next      = count_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_cv_next       = m_cv_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        m_err_next      = m_err_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.produce) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_char_next  = pend_char_reg;
                m_cv_next    = 1'b1;
                m_last_next  = 1'b0;
                m_done_next  = 1'b0;
                m_err_next   = 2'b00;
            end
            pend_valid_next = 1'b1;
            pend_char_next  = prod_char;
        end

        if (cmd.pop) begin
            count_next = count_dec;
        end

        if (cmd.push) begin
            if (full) begin
                err_next[0] = 1'b1;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end

        if (cmd.set_unmatched) begin
            err_next[1] = 1'b1;
        end

        if (cmd.finish) begin
            if (pend_valid_reg || eoe_reg) begin
                m_valid_next = 1'b1;
                m_char_next  = pend_valid_reg ? pend_char_reg : CH_NUL;
                m_cv_next    = pend_valid_reg;
                m_last_next  = 1'b1;
                m_done_next  = eoe_reg;
                m_err_next   = eoe_reg ? err_reg : 2'b00;
            end
            pend_valid_next = 1'b0;
            if (eoe_reg) begin
                err_next   = 2'b00;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            err_reg        <= 2'b00;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg  <= s_tdata;
            eoe_reg <= s_tlast;
        end
        pend_char_reg <= pend_char_next;
        m_char_reg    <= m_char_next;
        m_cv_reg      <= m_cv_next;
        m_last_reg    <= m_last_next;
        m_done_reg    <= m_done_next;
        m_err_reg     <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, m_err_reg, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_done_reg, m_cv_reg};

endmodule

/* sv/i2p_ctrl.sv */
// ============================================================================
// Infix to postfix controller
// Sequences decode, stack pops, pushes, the final flush and run completion.
// ============================================================================
`timescale 1ns / 1ps

module i2p_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  i2p_pkg::status_t status,
    output i2p_pkg::cmd_t    cmd
);
    import i2p_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_DECODE     = 8'b0000_0010,
        S_POP_CHK    = 8'b0000_0100,
        S_POP_WAIT   = 8'b0000_1000,
        S_NEXT       = 8'b0001_0000,
        S_FLUSH_CHK  = 8'b0010_0000,
        S_FLUSH_WAIT = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   can_emit;
    logic   stop_pop;

    assign can_emit = !status.pend_valid || status.out_free;
    assign stop_pop = status.empty || status.top_open || status.top_lower;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (status.cls)
                    CLS_SPACE: begin
                        state_next = S_NEXT;
                    end
                    CLS_OPEN: begin
                        cmd.push      = 1'b1;
                        cmd.push_open = 1'b1;
                        state_next    = S_NEXT;
                    end
                    CLS_CLOSE, CLS_OP: begin
                        state_next = S_POP_CHK;
                    end
                    default: begin
                        if (can_emit) begin
                            cmd.produce = 1'b1;
                            state_next  = S_NEXT;
                        end
                    end
                endcase
            end
            S_POP_CHK: begin
                if (status.cls == CLS_CLOSE) begin
                    if (status.empty) begin
                        cmd.set_unmatched = 1'b1;
                        state_next        = S_NEXT;
                    end else if (status.top_open) begin
                        cmd.pop    = 1'b1;
                        state_next = S_NEXT;
                    end else if (can_emit) begin
                        cmd.produce  = 1'b1;
                        cmd.prod_top = 1'b1;
                        cmd.pop      = 1'b1;
                        state_next   = S_POP_WAIT;
                    end
                end else begin
                    if (stop_pop) begin
                        cmd.push   = 1'b1;
                        state_next = S_NEXT;
                    end else if (can_emit) begin
                        cmd.produce  = 1'b1;
                        cmd.prod_top = 1'b1;
                        cmd.pop      = 1'b1;
                        state_next   = S_POP_WAIT;
                    end
                end
            end
            S_POP_WAIT: begin
                state_next = S_POP_CHK;
            end
            S_NEXT: begin
                state_next = status.eoe ? S_FLUSH_CHK : S_FINISH;
            end
            S_FLUSH_CHK: begin
                if (status.empty) begin
                    state_next = S_FINISH;
                end else if (can_emit) begin
                    cmd.produce  = 1'b1;
                    cmd.prod_top = 1'b1;
                    cmd.pop      = 1'b1;
                    state_next   = S_FLUSH_WAIT;
                end
            end
            S_FLUSH_WAIT: begin
                state_next = S_FLUSH_CHK;
            end
            S_FINISH: begin
                if (!(status.pend_valid || status.eoe) || status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
